@@ hw/rtl/qpid_pkg.sv @@
// Shared types, widths, register codes and reset constants for the
// quadrature-encoder PID position loop. No dependencies.
package qpid_pkg;

    localparam int GAIN_W    = 40;
    localparam int GAIN_LO_W = 20;          // gains are split in halves for the multipliers
    localparam int GAIN_HI_W = GAIN_W - GAIN_LO_W;
    localparam int CPR_W     = 16;
    localparam int RANGE_W   = 10;
    localparam int TGT_W     = 16;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = GAIN_W;

    localparam int GAIN_FRAC_BITS_DEF = 24;
    localparam int SUM_WIDTH_DEF      = 48;

    localparam logic [CPR_W-1:0]   CPR_RST   = 16'd216;
    localparam logic [GAIN_W-1:0]  KP_RST    = 40'd77672296;
    localparam logic [GAIN_W-1:0]  KI_RST    = 40'd16;
    localparam logic [GAIN_W-1:0]  KD_RST    = 40'd7767229630;
    localparam logic [RANGE_W-1:0] RANGE_RST = 10'd100;

    localparam logic signed [CNT_W-1:0] CNT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CNT_W-1:0] CNT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        MODE_EDGE   = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_TARGET = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CPR   = 3'd0,
        REG_KP    = 3'd1,
        REG_KI    = 3'd2,
        REG_KD    = 3'd3,
        REG_RANGE = 3'd4
    } t_cfg_reg;

    // per-beat control carried down the pipe alongside the arithmetic
    typedef struct packed {
        logic             tick;
        logic             e_pos;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] pos_err;
    } t_item_tag;

    // clamp a 34-bit signed value to the 32-bit signed range
    function automatic logic signed [CNT_W-1:0] sat32(input logic signed [33:0] v);
        if (v[33:31] != {3{v[33]}}) begin
            return v[33] ? CNT_MIN : CNT_MAX;
        end
        return v[31:0];
    endfunction

endpackage

@@ hw/rtl/qpid_state.sv @@
// Input register and loop state: edge count, reference, error sum, previous error.
// Produces error, sum and difference magnitudes for the gain multipliers. Uses qpid_pkg.
module qpid_state #(
    parameter int SUM_WIDTH = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_mode,
    input  logic                         i_edge_line,
    input  logic                         i_level_a,
    input  logic                         i_level_b,
    input  logic signed [qpid_pkg::TGT_W-1:0] i_target,
    input  logic [qpid_pkg::CPR_W-1:0]   i_cpr,
    output logic                         o_v,
    input  logic                         i_rdy,
    output qpid_pkg::t_item_tag          o_tag,
    output logic                         o_e_neg,
    output logic [qpid_pkg::CNT_W-1:0]   o_e_mag,
    output logic                         o_s_neg,
    output logic [SUM_WIDTH-1:0]         o_s_mag,
    output logic                         o_d_neg,
    output logic [qpid_pkg::CNT_W:0]     o_d_mag
);
    import qpid_pkg::*;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // input register
    logic                    r_v1;
    t_mode                   r_mode;
    logic                    r_line, r_la, r_lb;
    logic signed [TGT_W-1:0] r_tgt;

    // loop state
    logic signed [CNT_W-1:0]     r_count, r_ref, r_prev;
    logic signed [TGT_W-1:0]     r_last;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [CNT_W-1:0]     n_count, n_ref, n_prev;
    logic signed [TGT_W-1:0]     n_last;
    logic signed [SUM_WIDTH-1:0] n_sum;

    logic                    r_v2;
    logic                    rdy1, rdy2, adv;
    logic                    up;
    logic signed [TGT_W:0]   diff;
    logic signed [33:0]      ref_prod, e_raw, pe_raw;
    logic signed [CNT_W-1:0] e, ref_tgt, count_edge, pos_err;
    logic signed [SUM_WIDTH:0] sum_ext;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic signed [CNT_W:0]   d;

    assign rdy2    = !r_v2 || i_rdy;
    assign rdy1    = !r_v1 || rdy2;
    assign adv     = r_v1 && rdy2;
    assign o_ready = rdy1;
    assign o_v     = r_v2;

    always_comb begin
        diff     = {r_tgt[TGT_W-1], r_tgt} - {r_last[TGT_W-1], r_last};
        ref_prod = diff * $signed({1'b0, i_cpr});
        ref_tgt  = sat32(ref_prod);

        e_raw    = 34'(r_ref) - 34'(r_count);
        e        = sat32(e_raw);
        d        = 33'(e) - 33'(r_prev);

        sum_ext  = (SUM_WIDTH+1)'(r_sum) + (SUM_WIDTH+1)'(e);
        if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
            sum_sat = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_ext[SUM_WIDTH-1:0];
        end

        // A edge counts up on differing levels, B edge on matching levels
        up = r_line ^ r_la ^ r_lb;
        if (up) begin
            count_edge = (r_count == CNT_MAX) ? r_count : r_count + 32'sd1;
        end else begin
            count_edge = (r_count == CNT_MIN) ? r_count : r_count - 32'sd1;
        end

        n_count = r_count;
        n_ref   = r_ref;
        n_last  = r_last;
        n_sum   = r_sum;
        n_prev  = r_prev;
        unique case (r_mode)
            MODE_EDGE: begin
                n_count = count_edge;
            end
            MODE_TARGET: begin
                n_ref   = ref_tgt;
                n_last  = r_tgt;
                n_count = '0;
                n_sum   = '0;
                n_prev  = ref_tgt;
            end
            MODE_TICK: begin
                n_sum  = sum_sat;
                n_prev = e;
            end
            default: begin
            end
        endcase

        pe_raw  = 34'(n_ref) - 34'(n_count);
        pos_err = sat32(pe_raw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
        if (rdy1 && i_valid) begin
            r_mode <= t_mode'(i_mode);
            r_line <= i_edge_line;
            r_la   <= i_level_a;
            r_lb   <= i_level_b;
            r_tgt  <= i_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ref   <= '0;
            r_last  <= '0;
            r_sum   <= '0;
            r_prev  <= '0;
        end else if (adv) begin
            r_count <= n_count;
            r_ref   <= n_ref;
            r_last  <= n_last;
            r_sum   <= n_sum;
            r_prev  <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
        if (adv) begin
            o_tag.tick    <= (r_mode == MODE_TICK);
            o_tag.e_pos   <= !e[CNT_W-1] && (e != '0);
            o_tag.count   <= n_count;
            o_tag.pos_err <= pos_err;
            o_e_neg       <= e[CNT_W-1];
            o_e_mag       <= e[CNT_W-1] ? CNT_W'(-e) : CNT_W'(e);
            o_s_neg       <= sum_sat[SUM_WIDTH-1];
            o_s_mag       <= sum_sat[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_sat) : SUM_WIDTH'(sum_sat);
            o_d_neg       <= d[CNT_W];
            o_d_mag       <= d[CNT_W] ? (CNT_W+1)'(-d) : (CNT_W+1)'(d);
        end
    end

    // a new target restarts the count and the integrator
    a_target_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_mode == MODE_TARGET) |=> (r_count == '0 && r_sum == '0))
        else $error("count or error sum not cleared by new target");

    // the edge count sticks at its upper limit instead of wrapping
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_mode == MODE_EDGE && up && r_count == CNT_MAX) |=> (r_count == CNT_MAX))
        else $error("edge count wrapped at upper limit");

endmodule

@@ hw/rtl/qpid_mult.sv @@
// Gain multipliers: partial products of the split gains (one stage), then
// assembly of the three unsigned term magnitudes (one stage). Uses qpid_pkg.
module qpid_mult #(
    parameter int SUM_WIDTH = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_v,
    output logic                           o_rdy,
    input  qpid_pkg::t_item_tag            i_tag,
    input  logic                           i_e_neg,
    input  logic [qpid_pkg::CNT_W-1:0]     i_e_mag,
    input  logic                           i_s_neg,
    input  logic [SUM_WIDTH-1:0]           i_s_mag,
    input  logic                           i_d_neg,
    input  logic [qpid_pkg::CNT_W:0]       i_d_mag,
    input  logic [qpid_pkg::GAIN_W-1:0]    i_kp,
    input  logic [qpid_pkg::GAIN_W-1:0]    i_ki,
    input  logic [qpid_pkg::GAIN_W-1:0]    i_kd,
    output logic                           o_v,
    input  logic                           i_rdy,
    output qpid_pkg::t_item_tag            o_tag,
    output logic                           o_p_neg,
    output logic [qpid_pkg::GAIN_W+qpid_pkg::CNT_W-1:0]   o_p_mag,
    output logic                           o_i_neg,
    output logic [qpid_pkg::GAIN_W+SUM_WIDTH-1:0]         o_i_mag,
    output logic                           o_d_neg,
    output logic [qpid_pkg::GAIN_W+qpid_pkg::CNT_W:0]     o_d_mag
);
    import qpid_pkg::*;

    localparam int SLO  = SUM_WIDTH / 2;
    localparam int SHI  = SUM_WIDTH - SLO;
    localparam int PW   = GAIN_W + CNT_W;
    localparam int IW   = GAIN_W + SUM_WIDTH;
    localparam int DW   = GAIN_W + CNT_W + 1;
    localparam int EPW  = CNT_W + GAIN_LO_W;
    localparam int DPW  = CNT_W + 1 + GAIN_LO_W;

    logic            r_v3, rdy3, rdy4;
    t_item_tag       r_tag3;
    logic            r_en3, r_sn3, r_dn3;
    logic [EPW-1:0]  r_pl, r_ph;
    logic [SLO+GAIN_LO_W-1:0] r_ill, r_ilh;
    logic [SHI+GAIN_LO_W-1:0] r_ihl, r_ihh;
    logic [DPW-1:0]  r_dl, r_dh;
    logic [SLO-1:0]  s_lo;
    logic [SHI-1:0]  s_hi;

    assign rdy4  = !o_v || i_rdy;
    assign rdy3  = !r_v3 || rdy4;
    assign o_rdy = rdy3;
    assign s_lo  = i_s_mag[SLO-1:0];
    assign s_hi  = i_s_mag[SUM_WIDTH-1:SLO];

    // partial products, each no wider than about 20 x 33
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= i_v;
        end
        if (rdy3 && i_v) begin
            r_tag3 <= i_tag;
            r_en3  <= i_e_neg;
            r_sn3  <= i_s_neg;
            r_dn3  <= i_d_neg;
            r_pl   <= EPW'(i_e_mag) * EPW'(i_kp[GAIN_LO_W-1:0]);
            r_ph   <= EPW'(i_e_mag) * EPW'(i_kp[GAIN_W-1:GAIN_LO_W]);
            r_ill  <= (SLO+GAIN_LO_W)'(s_lo) * (SLO+GAIN_LO_W)'(i_ki[GAIN_LO_W-1:0]);
            r_ilh  <= (SLO+GAIN_LO_W)'(s_lo) * (SLO+GAIN_LO_W)'(i_ki[GAIN_W-1:GAIN_LO_W]);
            r_ihl  <= (SHI+GAIN_LO_W)'(s_hi) * (SHI+GAIN_LO_W)'(i_ki[GAIN_LO_W-1:0]);
            r_ihh  <= (SHI+GAIN_LO_W)'(s_hi) * (SHI+GAIN_LO_W)'(i_ki[GAIN_W-1:GAIN_LO_W]);
            r_dl   <= DPW'(i_d_mag) * DPW'(i_kd[GAIN_LO_W-1:0]);
            r_dh   <= DPW'(i_d_mag) * DPW'(i_kd[GAIN_W-1:GAIN_LO_W]);
        end
    end

    // shift and add partials into full-width magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_v <= 1'b0;
        end else if (rdy4) begin
            o_v <= r_v3;
        end
        if (rdy4 && r_v3) begin
            o_tag   <= r_tag3;
            o_p_neg <= r_en3;
            o_i_neg <= r_sn3;
            o_d_neg <= r_dn3;
            o_p_mag <= PW'(r_pl) + {r_ph, {GAIN_LO_W{1'b0}}};
            o_i_mag <= IW'(r_ill)
                     + IW'({r_ilh, {GAIN_LO_W{1'b0}}})
                     + IW'({r_ihl, {SLO{1'b0}}})
                     + {r_ihh, {(GAIN_LO_W+SLO){1'b0}}};
            o_d_mag <= DW'(r_dl) + {r_dh, {GAIN_LO_W{1'b0}}};
        end
    end

endmodule

@@ hw/rtl/qpid_drive.sv @@
// Signed PID sum, integer part, clamp to the drive range and steering to the
// forward or reverse output; holds the drive and the result register. Uses qpid_pkg.
module qpid_drive #(
    parameter int GAIN_FRAC_BITS = 24,
    parameter int SUM_WIDTH      = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_v,
    output logic                           o_rdy,
    input  qpid_pkg::t_item_tag            i_tag,
    input  logic                           i_p_neg,
    input  logic [qpid_pkg::GAIN_W+qpid_pkg::CNT_W-1:0]   i_p_mag,
    input  logic                           i_i_neg,
    input  logic [qpid_pkg::GAIN_W+SUM_WIDTH-1:0]         i_i_mag,
    input  logic                           i_d_neg,
    input  logic [qpid_pkg::GAIN_W+qpid_pkg::CNT_W:0]     i_d_mag,
    input  logic [qpid_pkg::RANGE_W-1:0]   i_range,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [qpid_pkg::RANGE_W-1:0]   o_drive_forward,
    output logic [qpid_pkg::RANGE_W-1:0]   o_drive_reverse,
    output logic                           o_drive_update,
    output logic [qpid_pkg::CNT_W-1:0]     o_edge_count,
    output logic [qpid_pkg::CNT_W-1:0]     o_position_error
);
    import qpid_pkg::*;

    localparam int UW  = GAIN_W + SUM_WIDTH + 3;
    localparam int IPW = UW - GAIN_FRAC_BITS;

    logic                 r_v5, rdy5, rdy6;
    t_item_tag            r_tag5;
    logic signed [UW-1:0] r_u;
    logic signed [UW-1:0] t_p, t_i, t_d, n_u;
    logic [UW-1:0]        u_mag;
    logic [IPW-1:0]       ip;
    logic [RANGE_W-1:0]   duty, n_fwd, n_rev;
    logic                 u_neg;
    logic [RANGE_W-1:0]   r_fwd, r_rev;

    assign rdy6  = !o_valid || i_ready;
    assign rdy5  = !r_v5 || rdy6;
    assign o_rdy = rdy5;

    always_comb begin
        t_p = $signed(UW'(i_p_mag));
        t_i = $signed(UW'(i_i_mag));
        t_d = $signed(UW'(i_d_mag));
        n_u = (i_p_neg ? -t_p : t_p) + (i_i_neg ? -t_i : t_i) + (i_d_neg ? -t_d : t_d);
    end

    // truncate toward zero: take the integer part of the magnitude
    always_comb begin
        u_neg = r_u[UW-1];
        u_mag = u_neg ? UW'(-r_u) : UW'(r_u);
        ip    = u_mag[UW-1:GAIN_FRAC_BITS];
        duty  = (ip > IPW'(i_range)) ? i_range : ip[RANGE_W-1:0];
        if (r_tag5.e_pos) begin
            n_fwd = u_neg ? '0 : duty;
            n_rev = '0;
        end else begin
            n_fwd = '0;
            n_rev = u_neg ? duty : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (rdy5) begin
            r_v5 <= i_v;
        end
        if (rdy5 && i_v) begin
            r_tag5 <= i_tag;
            r_u    <= n_u;
        end
    end

    // drive registers hold between ticks and double as the result fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_fwd   <= '0;
            r_rev   <= '0;
        end else begin
            if (rdy6) begin
                o_valid <= r_v5;
            end
            if (rdy6 && r_v5 && r_tag5.tick) begin
                r_fwd <= n_fwd;
                r_rev <= n_rev;
            end
        end
        if (rdy6 && r_v5) begin
            o_drive_update   <= r_tag5.tick;
            o_edge_count     <= r_tag5.count;
            o_position_error <= r_tag5.pos_err;
        end
    end

    assign o_drive_forward = r_fwd;
    assign o_drive_reverse = r_rev;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fwd != '0 && r_rev != '0))
        else $error("forward and reverse drive both active");

    a_hold_between_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rdy6 && r_v5 && !r_tag5.tick) |=> ($stable(r_fwd) && $stable(r_rev)))
        else $error("drive changed on a non-tick beat");

endmodule

@@ hw/rtl/quadrature_pid_position_control.sv @@
// Quadrature-encoder PID position loop, top level: config registers and pipeline.
// Throughput: one beat per cycle unless i_ready holds the output off; six registered
//   stages, each with its own valid bit, so bubbles fill even while a finished result
//   waits on the output.
// Reset (synchronous, active low): count, reference, sum and drives cleared,
//   configuration back to defaults, pipeline emptied.
module quadrature_pid_position_control #(
    parameter int GAIN_FRAC_BITS = qpid_pkg::GAIN_FRAC_BITS_DEF,
    parameter int SUM_WIDTH      = qpid_pkg::SUM_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [qpid_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [qpid_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input beats
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_mode,
    input  logic                               i_edge_line,
    input  logic                               i_level_a,
    input  logic                               i_level_b,
    input  logic signed [qpid_pkg::TGT_W-1:0]  i_target_rotations,
    // result beats
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [qpid_pkg::RANGE_W-1:0]       o_drive_forward,
    output logic [qpid_pkg::RANGE_W-1:0]       o_drive_reverse,
    output logic                               o_drive_update,
    output logic signed [qpid_pkg::CNT_W-1:0]  o_edge_count,
    output logic signed [qpid_pkg::CNT_W-1:0]  o_position_error
);
    import qpid_pkg::*;

    // configuration; only to be written while the pipe is idle, which the block does
    // not enforce itself, so later stages read it directly
    logic [CPR_W-1:0]   r_cpr;
    logic [GAIN_W-1:0]  r_kp, r_ki, r_kd;
    logic [RANGE_W-1:0] r_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr   <= CPR_RST;
            r_kp    <= KP_RST;
            r_ki    <= KI_RST;
            r_kd    <= KD_RST;
            r_range <= RANGE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_CPR:   r_cpr   <= i_cfg_data[CPR_W-1:0];
                REG_KP:    r_kp    <= i_cfg_data[GAIN_W-1:0];
                REG_KI:    r_ki    <= i_cfg_data[GAIN_W-1:0];
                REG_KD:    r_kd    <= i_cfg_data[GAIN_W-1:0];
                REG_RANGE: r_range <= i_cfg_data[RANGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage 1-2: input register, state update, error / sum / difference
    logic               st_v, st_rdy;
    t_item_tag          st_tag;
    logic               st_e_neg, st_s_neg, st_d_neg;
    logic [CNT_W-1:0]   st_e_mag;
    logic [SUM_WIDTH-1:0] st_s_mag;
    logic [CNT_W:0]     st_d_mag;

    qpid_state #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_edge_line (i_edge_line),
        .i_level_a   (i_level_a),
        .i_level_b   (i_level_b),
        .i_target    (i_target_rotations),
        .i_cpr       (r_cpr),
        .o_v         (st_v),
        .i_rdy       (st_rdy),
        .o_tag       (st_tag),
        .o_e_neg     (st_e_neg),
        .o_e_mag     (st_e_mag),
        .o_s_neg     (st_s_neg),
        .o_s_mag     (st_s_mag),
        .o_d_neg     (st_d_neg),
        .o_d_mag     (st_d_mag)
    );

    // stage 3-4: split-gain partial products, then term magnitudes
    logic               ml_v, ml_rdy;
    t_item_tag          ml_tag;
    logic               ml_p_neg, ml_i_neg, ml_d_neg;
    logic [GAIN_W+CNT_W-1:0]     ml_p_mag;
    logic [GAIN_W+SUM_WIDTH-1:0] ml_i_mag;
    logic [GAIN_W+CNT_W:0]       ml_d_mag;

    qpid_mult #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (st_v),
        .o_rdy   (st_rdy),
        .i_tag   (st_tag),
        .i_e_neg (st_e_neg),
        .i_e_mag (st_e_mag),
        .i_s_neg (st_s_neg),
        .i_s_mag (st_s_mag),
        .i_d_neg (st_d_neg),
        .i_d_mag (st_d_mag),
        .i_kp    (r_kp),
        .i_ki    (r_ki),
        .i_kd    (r_kd),
        .o_v     (ml_v),
        .i_rdy   (ml_rdy),
        .o_tag   (ml_tag),
        .o_p_neg (ml_p_neg),
        .o_p_mag (ml_p_mag),
        .o_i_neg (ml_i_neg),
        .o_i_mag (ml_i_mag),
        .o_d_neg (ml_d_neg),
        .o_d_mag (ml_d_mag)
    );

    // stage 5-6: PID sum, clamp, drive hold and result register
    qpid_drive #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SUM_WIDTH      (SUM_WIDTH)
    ) u_drive (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_v              (ml_v),
        .o_rdy            (ml_rdy),
        .i_tag            (ml_tag),
        .i_p_neg          (ml_p_neg),
        .i_p_mag          (ml_p_mag),
        .i_i_neg          (ml_i_neg),
        .i_i_mag          (ml_i_mag),
        .i_d_neg          (ml_d_neg),
        .i_d_mag          (ml_d_mag),
        .i_range          (r_range),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_drive_forward  (o_drive_forward),
        .o_drive_reverse  (o_drive_reverse),
        .o_drive_update   (o_drive_update),
        .o_edge_count     (o_edge_count),
        .o_position_error (o_position_error)
    );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the quadrature PID position loop: directed and random beats
// checked against a position-loop model kept in this file. Depends on qpid_pkg and the top level.
module tb_top;
    import qpid_pkg::*;

    localparam int FRAC_BITS = GAIN_FRAC_BITS_DEF;
    localparam int SUM_W     = SUM_WIDTH_DEF;
    localparam int LATENCY   = 5;                   // accept to result
    localparam int RANDOM_PHASES   = 8;
    localparam int BEATS_PER_PHASE = 220;
    localparam int RAIL_TICKS      = 32;            // full-rate ticks with the error at a rail

    // edge_line codes
    localparam logic LINE_A = 1'b0;
    localparam logic LINE_B = 1'b1;

    localparam logic [CFG_DATA_W-1:0] CPR_TOP  = 65535;
    localparam logic [CFG_DATA_W-1:0] DUTY_TOP = 1023;
    localparam logic [CFG_DATA_W-1:0] GAIN_TOP = {GAIN_W{1'b1}};

    typedef struct {
        t_mode                   mode;
        logic                    line;
        logic                    lvl_a;
        logic                    lvl_b;
        logic signed [TGT_W-1:0] target;
    } t_enc_beat;

    typedef struct {
        logic [RANGE_W-1:0]      fwd;
        logic [RANGE_W-1:0]      rev;
        logic                    upd;
        logic signed [CNT_W-1:0] count;
        logic signed [CNT_W-1:0] err;
    } t_loop_report;

    // DUT ports, all inputs known from time zero
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [1:0]                i_mode = '0;
    logic                      i_edge_line = 1'b0;
    logic                      i_level_a = 1'b0;
    logic                      i_level_b = 1'b0;
    logic signed [TGT_W-1:0]   i_target_rotations = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [RANGE_W-1:0]        o_drive_forward;
    logic [RANGE_W-1:0]        o_drive_reverse;
    logic                      o_drive_update;
    logic signed [CNT_W-1:0]   o_edge_count;
    logic signed [CNT_W-1:0]   o_position_error;

    quadrature_pid_position_control u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_edge_line        (i_edge_line),
        .i_level_a          (i_level_a),
        .i_level_b          (i_level_b),
        .i_target_rotations (i_target_rotations),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_drive_forward    (o_drive_forward),
        .o_drive_reverse    (o_drive_reverse),
        .o_drive_update     (o_drive_update),
        .o_edge_count       (o_edge_count),
        .o_position_error   (o_position_error)
    );

    // Mirror of the loop: configuration copy plus loop state, starting from reset values.
    logic [CPR_W-1:0]          mir_cpr      = CPR_RST;
    logic [GAIN_W-1:0]         mir_kp       = KP_RST;
    logic [GAIN_W-1:0]         mir_ki       = KI_RST;
    logic [GAIN_W-1:0]         mir_kd       = KD_RST;
    logic [RANGE_W-1:0]        mir_duty_max = RANGE_RST;
    logic signed [CNT_W-1:0]   mir_count    = '0;
    logic signed [CNT_W-1:0]   mir_ref      = '0;
    logic signed [CNT_W-1:0]   mir_prev_err = '0;
    logic signed [TGT_W-1:0]   mir_last_tgt = '0;
    logic signed [SUM_W-1:0]   mir_sum      = '0;
    logic [RANGE_W-1:0]        mir_fwd      = '0;
    logic [RANGE_W-1:0]        mir_rev      = '0;

    t_loop_report loop_reports_q[$];   // one entry per accepted beat, oldest first

    // encoder line levels as last sent, so quadrature steps follow a legal sequence
    logic enc_a = 1'b0;
    logic enc_b = 1'b0;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_req = 0;

    int fail_count      = 0;
    int beats_sent      = 0;
    int ticks_sent      = 0;
    int targets_sent    = 0;
    int reports_checked = 0;
    int input_stalls    = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #40_000_000;
        $display("Timeout: %0d result beats still expected", loop_reports_q.size());
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- loop model

    function automatic logic signed [CNT_W-1:0] clamp_to_s32(input logic signed [63:0] v);
        if (v > CNT_MAX) return CNT_MAX;
        if (v < CNT_MIN) return CNT_MIN;
        return v[CNT_W-1:0];
    endfunction

    // exact signed product of an unsigned gain and a signed operand
    function automatic logic signed [127:0] gain_times(input logic [GAIN_W-1:0] g,
                                                       input logic signed [63:0] v);
        logic signed [127:0] gs;
        logic signed [127:0] vs;
        gs = {{(128 - GAIN_W){1'b0}}, g};
        vs = v;
        return gs * vs;
    endfunction

    // integer part of a non-negative fixed-point magnitude, clamped to the drive limit
    function automatic logic [RANGE_W-1:0] duty_from(input logic signed [127:0] mag);
        logic [127:0] ip;
        ip = mag >>> FRAC_BITS;
        if (ip > mir_duty_max) return mir_duty_max;
        return ip[RANGE_W-1:0];
    endfunction

    // Advance the mirror by one beat and return the result beat it should produce.
    function automatic t_loop_report position_loop_step(input t_enc_beat b);
        t_loop_report        r;
        logic                up;
        logic signed [63:0]  tgt64, last64, cpr64, ref64, cnt64, prev64;
        logic signed [63:0]  e, d, sum64, smax, smin;
        logic signed [127:0] u;
        r.upd = 1'b0;
        case (b.mode)
            MODE_EDGE: begin
                // line A: up when levels differ; line B: up when they match
                up = (b.line == LINE_A) ? (b.lvl_a != b.lvl_b) : (b.lvl_a == b.lvl_b);
                if (up) begin
                    if (mir_count != CNT_MAX) mir_count = mir_count + 1;
                end else if (mir_count != CNT_MIN) begin
                    mir_count = mir_count - 1;
                end
            end
            MODE_TARGET: begin
                tgt64  = b.target;
                last64 = mir_last_tgt;
                cpr64  = {{(64 - CPR_W){1'b0}}, mir_cpr};
                mir_ref      = clamp_to_s32((tgt64 - last64) * cpr64);
                mir_last_tgt = b.target;
                mir_count    = '0;
                mir_sum      = '0;
                mir_prev_err = mir_ref;
            end
            MODE_TICK: begin
                ref64  = mir_ref;
                cnt64  = mir_count;
                prev64 = mir_prev_err;
                sum64  = mir_sum;
                smax   = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
                smin   = -smax - 64'sd1;
                e      = clamp_to_s32(ref64 - cnt64);
                d      = e - prev64;
                if (e > 0 && sum64 > smax - e) sum64 = smax;
                else if (e < 0 && sum64 < smin - e) sum64 = smin;
                else sum64 = sum64 + e;
                mir_sum = sum64[SUM_W-1:0];
                u = gain_times(mir_kp, e) + gain_times(mir_ki, sum64) + gain_times(mir_kd, d);
                // error sign picks the output; a drive opposing it is cut to zero
                if (e > 0) begin
                    mir_fwd = (u < 0) ? '0 : duty_from(u);
                    mir_rev = '0;
                end else begin
                    mir_fwd = '0;
                    mir_rev = (u < 0) ? duty_from(-u) : '0;
                end
                mir_prev_err = e[CNT_W-1:0];
                r.upd = 1'b1;
            end
            default: ;  // unused mode: state untouched
        endcase
        ref64 = mir_ref;
        cnt64 = mir_count;
        r.fwd   = mir_fwd;
        r.rev   = mir_rev;
        r.count = mir_count;
        r.err   = clamp_to_s32(ref64 - cnt64);
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[GAIN_W-1:0] >> $urandom_range(0, GAIN_W - 1);
    endfunction

    function automatic t_enc_beat mk_beat(input t_mode m, input logic line, input logic a,
                                          input logic b, input logic signed [TGT_W-1:0] t);
        t_enc_beat x;
        x.mode   = m;
        x.line   = line;
        x.lvl_a  = a;
        x.lvl_b  = b;
        x.target = t;
        return x;
    endfunction

    // Offer one beat (after an optional gap) and hold it until accepted.
    task automatic send_beat(input t_enc_beat b);
        int gap;
        int waited;
        gap = tx_idle_on ? pick_gap() : 0;
        waited = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_mode             <= b.mode;
        i_edge_line        <= b.line;
        i_level_a          <= b.lvl_a;
        i_level_b          <= b.lvl_b;
        i_target_rotations <= b.target;
        i_valid            <= 1'b1;
        do begin
            @(posedge i_clk);
            waited++;
        end while (!o_ready);
        if (waited > 1) input_stalls++;
        loop_reports_q.push_back(position_loop_step(b));
        beats_sent++;
        if (b.mode == MODE_TICK) ticks_sent++;
        if (b.mode == MODE_TARGET) targets_sent++;
    endtask

    task automatic send_edge(input logic line, input logic a, input logic b);
        enc_a = a;
        enc_b = b;
        send_beat(mk_beat(MODE_EDGE, line, a, b, TGT_W'($urandom)));
    endtask

    task automatic send_tick();
        send_beat(mk_beat(MODE_TICK, 1'($urandom), 1'($urandom), 1'($urandom),
                          TGT_W'($urandom)));
    endtask

    task automatic send_target(input logic signed [TGT_W-1:0] t);
        send_beat(mk_beat(MODE_TARGET, 1'($urandom), 1'($urandom), 1'($urandom), t));
    endtask

    task automatic send_unused();
        send_beat(mk_beat(MODE_NONE, 1'($urandom), 1'($urandom), 1'($urandom),
                          TGT_W'($urandom)));
    endtask

    // one legal quadrature step: exactly one of the two line toggles moves the wanted way
    task automatic step_encoder(input logic dir_up);
        logic a_moves_up;
        a_moves_up = ((~enc_a) != enc_b);
        if (a_moves_up == dir_up) send_edge(LINE_A, ~enc_a, enc_b);
        else send_edge(LINE_B, enc_a, ~enc_b);
    endtask

    // Wait until every expected result beat is in, then let the pipe settle.
    task automatic drain(input int settle);
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (loop_reports_q.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (loop_reports_q.size() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, loop_reports_q.size());
            fail_count++;
            loop_reports_q.delete();
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // Write all five registers back to back while the block is idle.
    task automatic load_config(input logic [CFG_DATA_W-1:0] cpr, input logic [CFG_DATA_W-1:0] kp,
                               input logic [CFG_DATA_W-1:0] ki, input logic [CFG_DATA_W-1:0] kd,
                               input logic [CFG_DATA_W-1:0] duty_max);
        t_cfg_reg              idx [5] = '{REG_CPR, REG_KP, REG_KI, REG_KD, REG_RANGE};
        logic [CFG_DATA_W-1:0] vals [5];
        vals = '{cpr, kp, ki, kd, duty_max};
        drain(LATENCY + 3);
        for (int k = 0; k < 5; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_wr_en  <= 1'b0;
        mir_cpr      = cpr[CPR_W-1:0];
        mir_kp       = kp[GAIN_W-1:0];
        mir_ki       = ki[GAIN_W-1:0];
        mir_kd       = kd[GAIN_W-1:0];
        mir_duty_max = duty_max[RANGE_W-1:0];
    endtask

    // ---------------------------------------------------------------- receiver side

    // Random stalls, plus long hold-offs on request, counted here cycle by cycle.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string what, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 50)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // every result beat is compared against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (loop_reports_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 50)
                    $display("%0t: result beat with nothing expected: expected none, actual count %0d",
                             $time, o_edge_count);
            end else begin : compare
                t_loop_report want;
                want = loop_reports_q.pop_front();
                check_field("drive_forward", want.fwd, o_drive_forward);
                check_field("drive_reverse", want.rev, o_drive_reverse);
                check_field("drive_update", want.upd, o_drive_update);
                check_field("edge_count", want.count, o_edge_count);
                check_field("position_error", want.err, o_position_error);
                reports_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Reset configuration: every edge rule, unused mode, targets at both ends.
    task automatic test_reset_defaults();
        send_edge(LINE_A, 1'b1, 1'b0);      // A edge, levels differ: up
        send_edge(LINE_A, 1'b0, 1'b0);      // A edge, levels match: down
        send_edge(LINE_B, 1'b1, 1'b1);      // B edge, levels match: up
        send_edge(LINE_B, 1'b0, 1'b1);      // B edge, levels differ: down
        send_unused();
        send_tick();
        send_target(16'sd3);
        send_tick();
        repeat (3) step_encoder(1'b1);
        send_tick();
        send_tick();
        send_target(16'sh7FFF);
        send_tick();
        send_target(16'sh8000);
        send_tick();
    endtask

    // Largest scale, gains and drive: reference saturates both ways, drive pinned.
    task automatic test_gain_extremes();
        load_config(CPR_TOP, GAIN_TOP, GAIN_TOP, GAIN_TOP, DUTY_TOP);
        send_target(16'sh7FFF);
        send_tick();
        step_encoder(1'b0);
        step_encoder(1'b0);
        send_tick();
        send_target(16'sh8000);
        send_tick();
        send_unused();
    endtask

    // Zero scale and zero drive limit: reference and drive stay zero.
    task automatic test_zero_scales();
        load_config('0, KP_RST, KI_RST, KD_RST, '0);
        send_target(16'sd5);
        send_tick();
        step_encoder(1'b1);
        send_tick();
    endtask

    // Pin the error at each rail and tick at full rate with I gain only:
    // the sum runs far from zero in both directions, drive pinned at the limit.
    task automatic test_sum_rails();
        load_config(CPR_TOP, '0, 40'd1, '0, DUTY_TOP);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_target(16'sh8000);
        send_target(16'sh7FFF);
        repeat (RAIL_TICKS) send_tick();
        send_target(16'sh8000);
        repeat (RAIL_TICKS) send_tick();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver holds off while beats keep coming: the pipe fills and input stalls.
    task automatic test_backpressure();
        load_config(40'd20, KP_RST, KI_RST, KD_RST, RANGE_RST);
        send_target(16'sd2);
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = 300;
        for (int k = 0; k < 60; k++) begin
            if (k % 5 == 4) send_tick();
            else step_encoder(k < 40);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // One random beat: mostly legal quadrature motion steered toward the reference,
    // with ticks, new targets, glitchy edges and the unused mode mixed in.
    task automatic random_beat();
        int   pick;
        int   t;
        logic dir;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            if ($urandom_range(0, 4) != 0) dir = (mir_ref > mir_count);
            else dir = 1'($urandom);
            step_encoder(dir);
        end else if (pick < 84) begin
            send_tick();
        end else if (pick < 90) begin
            send_edge(1'($urandom), 1'($urandom), 1'($urandom));
        end else if (pick < 97) begin
            if ($urandom_range(0, 4) != 0) t = int'(mir_last_tgt) + $urandom_range(0, 8) - 4;
            else t = $urandom_range(0, 65535);
            send_target(t[TGT_W-1:0]);
        end else begin
            send_unused();
        end
    endtask

    task automatic test_random_mix();
        logic [CFG_DATA_W-1:0] cpr;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            cpr = $urandom_range(1, 40);
            case (phase)
                0: load_config(CPR_RST, KP_RST, KI_RST, KD_RST, RANGE_RST);
                1: load_config(40'd1, rand_gain(), rand_gain(), rand_gain(), DUTY_TOP);
                2: load_config(CPR_TOP, rand_gain(), rand_gain(), rand_gain(), 40'd1);
                3: load_config(cpr, '0, '0, '0, $urandom_range(1, 1023));
                4: load_config(cpr, GAIN_TOP, GAIN_TOP, GAIN_TOP, DUTY_TOP);
                default: load_config(cpr, rand_gain(), rand_gain(), rand_gain(),
                                     $urandom_range(1, 1023));
            endcase
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // stretches with and without idling on either side
                if (n % 48 == 0) begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                random_beat();
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_gain_extremes();
        test_zero_scales();
        test_sum_rails();
        test_backpressure();
        test_random_mix();
        drain(LATENCY + 5);
        $display("Sent %0d beats (%0d ticks, %0d targets), checked %0d results, %0d input stalls",
                 beats_sent, ticks_sent, targets_sent, reports_checked, input_stalls);
        $display("Covered reset gains, extreme and zero scales, large error sums both ways, "
                 , "long output hold-off and %0d random config phases", RANDOM_PHASES);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ quadrature_pid_position_control.f @@
hw/rtl/qpid_pkg.sv
hw/rtl/qpid_state.sv
hw/rtl/qpid_mult.sv
hw/rtl/qpid_drive.sv
hw/rtl/quadrature_pid_position_control.sv
tb/sv/tb_top.sv
